// File: rtl/power_sequencer_wake_timer_macros.svh
// Assertion macros for the power sequencer wake timer.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef POWER_SEQUENCER_WAKE_TIMER_MACROS_SVH
`define POWER_SEQUENCER_WAKE_TIMER_MACROS_SVH

// Same-cycle implication.
`define PWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pws_pkg.sv
// Shared types, command codes and constants for the power sequencer wake timer.
// No dependencies.
package pws_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_MINUTE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAKE_CODE_RESET  = 2'd2;

  localparam logic [7:0] SHUTDOWN_DELAY_RST   = 8'd30;
  localparam logic [7:0] TICKS_PER_MINUTE_RST = 8'd60;
  localparam logic [2:0] WAKE_CODE_RST        = 3'd0;

  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0] CMD_SHUTDOWN  = 8'h53; // 'S'
  localparam logic [7:0] CMD_CANCEL    = 8'h43; // 'C'
  localparam logic [7:0] CMD_LED_R_SET = 8'h52; // 'R'
  localparam logic [7:0] CMD_LED_R_CLR = 8'h72; // 'r'
  localparam logic [7:0] CMD_LED_G_SET = 8'h47; // 'G'
  localparam logic [7:0] CMD_LED_G_CLR = 8'h67; // 'g'
  localparam logic [7:0] CMD_WAKE_0    = 8'h30; // '0'
  localparam logic [7:0] CMD_WAKE_1    = 8'h31; // '1'
  localparam logic [7:0] CMD_WAKE_5    = 8'h35; // '5'
  localparam logic [7:0] CMD_WAKE_15   = 8'h46; // 'F'
  localparam logic [7:0] CMD_WAKE_60   = 8'h48; // 'H'
  localparam logic [7:0] CMD_WAKE_8H   = 8'h38; // '8'
  localparam logic [7:0] CMD_WAKE_24H  = 8'h44; // 'D'

  localparam logic [2:0] WAKE_CODE_NONE = 3'd0;
  localparam logic [2:0] WAKE_CODE_1M   = 3'd1;
  localparam logic [2:0] WAKE_CODE_5M   = 3'd2;
  localparam logic [2:0] WAKE_CODE_15M  = 3'd3;
  localparam logic [2:0] WAKE_CODE_60M  = 3'd4;
  localparam logic [2:0] WAKE_CODE_8H   = 3'd5;
  localparam logic [2:0] WAKE_CODE_24H  = 3'd6;

  typedef struct packed {
    logic       func;
    logic [7:0] cmd_byte;
    logic       ac_line_level;
    logic       button_pressed;
  } in_item_t;

  typedef struct packed {
    logic       relay_on;
    logic       red_led;
    logic       grn_led;
    logic [6:0] status_byte;
    logic       asleep;
    logic       shutdown_pending;
    logic [7:0] delay_left;
  } out_item_t;

  typedef struct packed {
    logic [7:0] shutdown_delay;
    logic [7:0] ticks_per_minute;
    logic       wc_load;
    logic [2:0] wc_value;
  } cfg_t;

  typedef struct packed {
    logic        relay_closed;
    logic        red_lit;
    logic        green_lit;
    logic        shutdown_req;
    logic        countdown_active;
    logic [7:0]  countdown_secs;
    logic        sleeping;
    logic [2:0]  wake_code;
    logic [10:0] wake_minutes_left;
    logic [7:0]  minute_prescale;
    logic        ac_prev;
  } state_t;

  function automatic logic [10:0] wake_minutes(input logic [2:0] code);
    logic [10:0] m;
    case (code)
      WAKE_CODE_1M:  m = 11'd1;
      WAKE_CODE_5M:  m = 11'd5;
      WAKE_CODE_15M: m = 11'd15;
      WAKE_CODE_60M: m = 11'd60;
      WAKE_CODE_8H:  m = 11'd480;
      WAKE_CODE_24H: m = 11'd1440;
      default:       m = 11'd0;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] legal_code(input logic [2:0] code);
    return (code == 3'd7) ? WAKE_CODE_NONE : code;
  endfunction

endpackage

// File: rtl/power_sequencer_wake_timer.sv
// Power sequencer wake timer: one request per clock cycle while the result side is not stalled; each
// accepted request passes the input register, then the state update into the result register.
// The result register lets a new request in while a finished result waits to be taken.
// Depends on pws_pkg, pws_cfg and pws_ctrl.
module power_sequencer_wake_timer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pws_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pws_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [pws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pws_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic               in_valid_q;
  pws_pkg::in_item_t  in_q;
  logic               out_valid_q;
  pws_pkg::out_item_t out_q;
  pws_pkg::out_item_t result;
  pws_pkg::cfg_t      cfg;
  logic               out_adv;
  logic               step;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  pws_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pws_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (step),
    .item_i  (in_q),
    .result_o(result)
  );

  // Hold the request while the result side is blocked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/pws_cfg.sv
// Configuration registers of the power sequencer wake timer.
// Depends on pws_pkg.
module pws_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pws_pkg::CfgDataW-1:0] cfg_wdata_i,
  output pws_pkg::cfg_t                cfg_o
);

  logic [7:0] shutdown_delay_q;
  logic [7:0] ticks_per_minute_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutdown_delay_q   <= pws_pkg::SHUTDOWN_DELAY_RST;
      ticks_per_minute_q <= pws_pkg::TICKS_PER_MINUTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pws_pkg::CFG_SHUTDOWN_DELAY:   shutdown_delay_q   <= cfg_wdata_i;
        pws_pkg::CFG_TICKS_PER_MINUTE: ticks_per_minute_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The reset wake code only matters as a reload of the live wake code.
  always_comb begin
    cfg_o.shutdown_delay   = shutdown_delay_q;
    cfg_o.ticks_per_minute = (ticks_per_minute_q == 8'd0) ? 8'd1 : ticks_per_minute_q;
    cfg_o.wc_load          = cfg_we_i && (cfg_idx_i == pws_pkg::CFG_WAKE_CODE_RESET);
    cfg_o.wc_value         = pws_pkg::legal_code(cfg_wdata_i[2:0]);
  end

endmodule

// File: rtl/pws_ctrl.sv
// Sequencer state and its per-request update: commands, countdown, wake timer.
// Depends on pws_pkg and power_sequencer_wake_timer_macros.svh.
`include "power_sequencer_wake_timer_macros.svh"

module pws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pws_pkg::cfg_t      cfg_i,
  input  logic               step_i,
  input  pws_pkg::in_item_t  item_i,
  output pws_pkg::out_item_t result_o
);

  pws_pkg::state_t st_q, st_d;

  logic       rise;
  logic       expired;
  logic [7:0] prescale_inc;
  logic [7:0] secs_dec;

  function automatic pws_pkg::state_t reset_state();
    pws_pkg::state_t s;
    s              = '0;
    s.relay_closed = 1'b1;
    s.wake_code    = pws_pkg::legal_code(pws_pkg::WAKE_CODE_RST);
    return s;
  endfunction

  always_comb begin
    st_d         = st_q;
    expired      = 1'b0;
    rise         = item_i.ac_line_level && !st_q.ac_prev;
    prescale_inc = st_q.minute_prescale + 8'd1;
    secs_dec     = (st_q.countdown_secs != 8'd0) ? st_q.countdown_secs - 8'd1 : 8'd0;

    if (st_q.sleeping) begin
      if (item_i.func == pws_pkg::FUNC_TICK) begin
        if (prescale_inc < cfg_i.ticks_per_minute) begin
          st_d.minute_prescale = prescale_inc;
        end else begin
          st_d.minute_prescale = 8'd0;
          if (st_q.wake_minutes_left != 11'd0) begin
            st_d.wake_minutes_left = st_q.wake_minutes_left - 11'd1;
            expired = (st_q.wake_minutes_left == 11'd1);
          end
        end
      end
    end else if (item_i.func == pws_pkg::FUNC_CMD) begin
      case (item_i.cmd_byte)
        pws_pkg::CMD_SHUTDOWN: begin
          st_d.shutdown_req     = 1'b1;
          st_d.countdown_active = 1'b1;
          st_d.countdown_secs   = cfg_i.shutdown_delay;
        end
        pws_pkg::CMD_CANCEL: begin
          st_d.shutdown_req     = 1'b0;
          st_d.countdown_active = 1'b0;
          st_d.countdown_secs   = 8'd0;
        end
        pws_pkg::CMD_LED_R_SET: st_d.red_lit   = 1'b1;
        pws_pkg::CMD_LED_R_CLR: st_d.red_lit   = 1'b0;
        pws_pkg::CMD_LED_G_SET: st_d.green_lit = 1'b1;
        pws_pkg::CMD_LED_G_CLR: st_d.green_lit = 1'b0;
        pws_pkg::CMD_WAKE_0:    st_d.wake_code = pws_pkg::WAKE_CODE_NONE;
        pws_pkg::CMD_WAKE_1:    st_d.wake_code = pws_pkg::WAKE_CODE_1M;
        pws_pkg::CMD_WAKE_5:    st_d.wake_code = pws_pkg::WAKE_CODE_5M;
        pws_pkg::CMD_WAKE_15:   st_d.wake_code = pws_pkg::WAKE_CODE_15M;
        pws_pkg::CMD_WAKE_60:   st_d.wake_code = pws_pkg::WAKE_CODE_60M;
        pws_pkg::CMD_WAKE_8H:   st_d.wake_code = pws_pkg::WAKE_CODE_8H;
        pws_pkg::CMD_WAKE_24H:  st_d.wake_code = pws_pkg::WAKE_CODE_24H;
        default: ;
      endcase
    end else if (st_q.countdown_active && st_q.shutdown_req) begin
      st_d.countdown_secs = secs_dec;
      // Countdown done: open the relay and arm the wake timer.
      if (secs_dec == 8'd0) begin
        st_d.countdown_active  = 1'b0;
        st_d.relay_closed      = 1'b0;
        st_d.sleeping          = 1'b1;
        st_d.wake_minutes_left = pws_pkg::wake_minutes(st_q.wake_code);
        st_d.minute_prescale   = 8'd0;
      end
    end

    // Wake sources; the awake case uses the just-updated request flag.
    if ((st_q.sleeping && (item_i.button_pressed || rise || expired)) ||
        (!st_q.sleeping && rise && st_d.shutdown_req)) begin
      st_d.relay_closed      = 1'b1;
      st_d.sleeping          = 1'b0;
      st_d.shutdown_req      = 1'b0;
      st_d.countdown_active  = 1'b0;
      st_d.countdown_secs    = 8'd0;
      st_d.wake_minutes_left = 11'd0;
      st_d.minute_prescale   = 8'd0;
    end

    st_d.ac_prev = item_i.ac_line_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
    end else if (step_i) begin
      st_q <= st_d;
    end else if (cfg_i.wc_load) begin
      st_q.wake_code <= cfg_i.wc_value;
    end
  end

  always_comb begin
    result_o.relay_on         = st_d.relay_closed;
    result_o.red_led          = st_d.red_lit;
    result_o.grn_led          = st_d.green_lit;
    result_o.status_byte      = {st_d.wake_code, !item_i.ac_line_level,
                                 st_d.green_lit, st_d.red_lit, 1'b0};
    result_o.asleep           = st_d.sleeping;
    result_o.shutdown_pending = st_d.shutdown_req;
    result_o.delay_left       = st_d.countdown_secs;
  end

  `PWS_ASSERT_IMP(a_sleep_relay_open, st_q.sleeping, !st_q.relay_closed, "relay closed while asleep")
  `PWS_ASSERT_IMP(a_countdown_has_req, st_q.countdown_active, st_q.shutdown_req, "countdown without request")
  `PWS_ASSERT_IMP(a_awake_timer_idle, !st_q.sleeping, st_q.wake_minutes_left == 11'd0, "wake timer armed while awake")
  `PWS_ASSERT_NXT(a_button_wakes, step_i && st_q.sleeping && item_i.button_pressed, !st_q.sleeping, "button failed to wake")

endmodule
